/* rtl/dmht_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the direct-mapped cache hit tracker.
package dmht_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned OffsetW  = 5;
  localparam int unsigned LineW    = AddrW - OffsetW;
  localparam int unsigned SetW     = 10;
  localparam int unsigned Lines    = 1 << SetW;
  localparam int unsigned IdxMin   = 5;
  localparam int unsigned IdxMax   = 10;
  localparam int unsigned TagW     = LineW - IdxMin;
  localparam int unsigned CntW     = 32;
  localparam int unsigned CfgW     = 4;
  localparam int unsigned OutDataW = ((1 + 2 * CntW + 7) / 8) * 8;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic valid;
    logic hit;
  } cnt_upd_t;

  typedef struct packed {
    logic            we;
    logic [SetW-1:0] waddr;
    logic [TagW-1:0] wdata;
    logic            re;
    logic [SetW-1:0] raddr;
  } ram_req_t;

endpackage

/* rtl/direct_mapped_cache_hit_tracker_unit.sv */
`timescale 1ns / 1ps
// Top level of the direct-mapped cache hit tracker.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata[31:0] address
//   m_axis   | out       | tdata[0] hit, [32:1] hit_count, [64:33] access_count
//   cfg      | in        | cfg_wdata_i[3:0] index_bits
//
// One item per cycle: the tag memory read is issued at acceptance, the compare and
// write-back happen in the next cycle, with forwarding for the same set back to back.
// After reset a clearing pass writes zero to all 1024 tag entries, one per cycle;
// no item is accepted until the pass is done.
// A stalled result holds the compare stage, which holds the input.
module direct_mapped_cache_hit_tracker_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dmht_pkg::AddrW-1:0]          s_axis_tdata,   // address
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dmht_pkg::OutDataW-1:0]       m_axis_tdata,   // hit, hit_count, access_count
  input  logic                                cfg_we_i,
  input  logic [dmht_pkg::CfgW-1:0]           cfg_wdata_i     // index_bits
);

  dmht_pkg::state_e state_q, state_d;

  logic [dmht_pkg::CfgW-1:0] idx_bits_q;
  logic [dmht_pkg::CfgW-1:0] eff_bits;
  logic [dmht_pkg::SetW-1:0] clr_cnt_q, clr_cnt_d;

  logic [dmht_pkg::LineW-1:0] line;
  logic [dmht_pkg::LineW-1:0] line_shr;
  logic [dmht_pkg::SetW-1:0]  set_mask;
  logic [dmht_pkg::SetW-1:0]  new_set;
  logic [dmht_pkg::TagW-1:0]  new_tag;

  logic                      s1_valid_q, s1_valid_d;
  logic [dmht_pkg::SetW-1:0] s1_set_q;
  logic [dmht_pkg::TagW-1:0] s1_tag_q;
  logic                      fwd_valid_q;
  logic [dmht_pkg::TagW-1:0] fwd_tag_q;

  logic                      run;
  logic                      accept;
  logic                      out_free;
  logic                      s1_done;
  logic [dmht_pkg::TagW-1:0] rdata;
  logic [dmht_pkg::TagW-1:0] stored;
  logic                      hit;

  dmht_pkg::ram_req_t ram_req;
  dmht_pkg::cnt_upd_t cnt_upd;

  logic                      res_hit;
  logic [dmht_pkg::CntW-1:0] res_hits;
  logic [dmht_pkg::CntW-1:0] res_acc;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_bits_q <= dmht_pkg::CfgW'(dmht_pkg::IdxMin);
    end else if (cfg_we_i) begin
      idx_bits_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (idx_bits_q < dmht_pkg::CfgW'(dmht_pkg::IdxMin)) begin
      eff_bits = dmht_pkg::CfgW'(dmht_pkg::IdxMin);
    end else if (idx_bits_q > dmht_pkg::CfgW'(dmht_pkg::IdxMax)) begin
      eff_bits = dmht_pkg::CfgW'(dmht_pkg::IdxMax);
    end else begin
      eff_bits = idx_bits_q;
    end
  end

  // address split
  assign line     = s_axis_tdata[dmht_pkg::AddrW-1:dmht_pkg::OffsetW];
  assign line_shr = line >> eff_bits;
  assign set_mask = ~(('1) << eff_bits);
  assign new_set  = line[dmht_pkg::SetW-1:0] & set_mask;
  assign new_tag  = line_shr[dmht_pkg::TagW-1:0];

  // state machine: next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      dmht_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + dmht_pkg::SetW'(1);
        if (clr_cnt_q == '1) begin
          state_d = dmht_pkg::ST_RUN;
        end
      end
      dmht_pkg::ST_RUN: begin
        state_d = dmht_pkg::ST_RUN;
      end
      default: begin
        state_d = dmht_pkg::ST_CLEAR;
      end
    endcase
  end

  // state machine: outputs
  always_comb begin
    case (state_q)
      dmht_pkg::ST_RUN: run = 1'b1;
      default:          run = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dmht_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // compare stage
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_done       = s1_valid_q && out_free;
  assign s_axis_tready = run && (!s1_valid_q || out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign stored        = fwd_valid_q ? fwd_tag_q : rdata;
  assign hit           = (stored == s1_tag_q);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_set_q    <= new_set;
      s1_tag_q    <= new_tag;
      fwd_valid_q <= s1_done && (s1_set_q == new_set);
      fwd_tag_q   <= s1_tag_q;
    end
  end

  // memory access
  always_comb begin
    ram_req.re    = accept;
    ram_req.raddr = new_set;
    if (run) begin
      ram_req.we    = s1_done && !hit;
      ram_req.waddr = s1_set_q;
      ram_req.wdata = s1_tag_q;
    end else begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_cnt_q;
      ram_req.wdata = '0;
    end
  end

  dmht_tag_ram u_tag_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  assign cnt_upd.valid = s1_done;
  assign cnt_upd.hit   = hit;

  dmht_hit_counter u_hit_counter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (cnt_upd),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .hit_o          (res_hit),
    .hit_count_o    (res_hits),
    .access_count_o (res_acc)
  );

  assign m_axis_tdata = dmht_pkg::OutDataW'({res_acc, res_hits, res_hit});

endmodule

/* rtl/dmht_tag_ram.sv */
`timescale 1ns / 1ps
// Tag memory: one write port, one read port, registered read data.
module dmht_tag_ram (
  input  logic                           clk_i,
  input  dmht_pkg::ram_req_t             req_i,
  output logic [dmht_pkg::TagW-1:0]      rdata_o
);

  logic [dmht_pkg::TagW-1:0] mem [dmht_pkg::Lines];
  logic [dmht_pkg::TagW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dmht_hit_counter.sv */
`timescale 1ns / 1ps
// Saturating hit and access counters with the result output register.
module dmht_hit_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dmht_pkg::cnt_upd_t                upd_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              hit_o,
  output logic [dmht_pkg::CntW-1:0]         hit_count_o,
  output logic [dmht_pkg::CntW-1:0]         access_count_o
);

  logic                      valid_q, valid_d;
  logic                      hit_q;
  logic [dmht_pkg::CntW-1:0] hits_q, hits_d;
  logic [dmht_pkg::CntW-1:0] acc_q, acc_d;

  always_comb begin
    hits_d  = hits_q;
    acc_d   = acc_q;
    valid_d = valid_q && !out_ready_i;
    if (upd_i.valid) begin
      valid_d = 1'b1;
      if (upd_i.hit && (hits_q != '1)) begin
        hits_d = hits_q + dmht_pkg::CntW'(1);
      end
      if (acc_q != '1) begin
        acc_d = acc_q + dmht_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hits_q  <= '0;
      acc_q   <= '0;
    end else begin
      valid_q <= valid_d;
      hits_q  <= hits_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.valid) begin
      hit_q <= upd_i.hit;
    end
  end

  assign out_valid_o    = valid_q;
  assign hit_o          = hit_q;
  assign hit_count_o    = hits_q;
  assign access_count_o = acc_q;

endmodule
